[sv/pli_pkg.sv]
// Package for the piecewise-linear interpolation table.
// Holds table sizing, command/status codes, request/response types and
// the command/status bundles between controller and datapath. No dependencies.
package pli_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int QW         = 32;
  localparam int ProdW      = 2 * QW;

  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdQuery  = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  localparam logic [1:0] StInterp    = 2'd0;
  localparam logic [1:0] StNoBracket = 2'd1;
  localparam logic [1:0] StStored    = 2'd2;
  localparam logic [1:0] StFull      = 2'd3;

  localparam logic [1:0] ResZero   = 2'd0;
  localparam logic [1:0] ResLow    = 2'd1;
  localparam logic [1:0] ResInterp = 2'd2;

  localparam logic signed [QW-1:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] QMin = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]           cmd;
    logic signed [QW-1:0] key;
    logic signed [QW-1:0] entry_value;
  } req_t;

  typedef struct packed {
    logic signed [QW-1:0] result;
    logic [1:0]           status;
  } rsp_t;

  typedef struct packed {
    logic       key_ld;
    logic       wr;
    logic       clr;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       rd;
    logic       prev_ld;
    logic       diff_ld;
    logic       mul_ld;
    logic       div_start;
    logic       rsp_we;
    logic [1:0] rsp_status;
    logic [1:0] res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic few;
    logic ge;
    logic last;
    logic wpos;
    logic div_done;
  } dp_sts_t;

endpackage

[sv/piecewise_linear_interpolator.sv]
// Piecewise-linear interpolation table, signed Q16.16; top level.
// Append, clear and queries with fewer than two entries: result in the cycle after the
// request and busy stays low, so one per cycle. Query: entries are compared one per
// cycle through the memory read port, then a bit-serial divide; a non-positive width
// skips the divide, and no bracket ends the scan. Results cannot stall.
// Async active-low reset empties the table; stored entries are not cleared.
module piecewise_linear_interpolator import pli_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  pli_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (req_i.cmd),
    .sts_i   (dp_sts),
    .dp_o    (dp_cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  pli_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .rsp_o  (rsp_o)
  );

endmodule

[sv/pli_div.sv]
// Restoring unsigned divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Depends on pli_pkg.
module pli_div import pli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] dividend_i,
  input  logic [QW-1:0]    divisor_i,
  output logic             done_o,
  output logic [ProdW-1:0] quo_o
);

  localparam int StepW = $clog2(ProdW);
  localparam logic [StepW-1:0] LastStep = StepW'(ProdW - 1);

  logic [ProdW-1:0] quo_q;
  logic [QW-1:0]    rem_q, dvs_q;
  logic [StepW-1:0] cnt_q;
  logic             run_q, done_q;

  logic [QW:0]   trial;
  logic [QW:0]   diff;
  logic          take;

  assign trial = {rem_q, quo_q[ProdW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == LastStep);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      rem_q <= take ? diff[QW-1:0] : trial[QW-1:0];
      quo_q <= {quo_q[ProdW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[sv/pli_datapath.sv]
// Datapath: breakpoint memories, entry counter, scan pointer, difference,
// multiply and divide stages, saturation and the response register.
// Depends on pli_pkg and pli_div.
module pli_datapath import pli_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);

  logic signed [QW-1:0] key_mem [TableDepth];
  logic signed [QW-1:0] val_mem [TableDepth];

  logic [CntW-1:0]      cnt_q, ptr_q;
  logic signed [QW-1:0] key_q;
  logic signed [QW-1:0] rk_q, rv_q, pk_q, pv_q;

  logic [QW-1:0]        dym_q, dxm_q, w_q;
  logic                 neg_q, wpos_q;
  logic signed [QW-1:0] y1_q;
  logic [ProdW-1:0]     prod_q, prod_d;
  rsp_t                 rsp_q;

  logic signed [QW:0]   w_d, dy_d, dx_d;
  logic [QW:0]          dyn, dxn;
  logic                 div_done;
  logic [ProdW-1:0]     quo;

  logic signed [QW+1:0] y1x, qx, sum;
  logic signed [QW-1:0] sat_res;
  logic signed [QW-1:0] res_d;

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      key_mem[cnt_q[IdxW-1:0]] <= req_i.key;
      val_mem[cnt_q[IdxW-1:0]] <= req_i.entry_value;
    end
    if (cmd_i.rd) begin
      rk_q <= key_mem[ptr_q[IdxW-1:0]];
      rv_q <= val_mem[ptr_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        cnt_q <= '0;
      end else if (cmd_i.wr) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // differences against the lower breakpoint
  assign w_d  = (QW+1)'(rk_q) - (QW+1)'(pk_q);
  assign dy_d = (QW+1)'(rv_q) - (QW+1)'(pv_q);
  assign dx_d = (QW+1)'(key_q) - (QW+1)'(pk_q);
  assign dyn  = -dy_d;
  assign dxn  = -dx_d;
  assign prod_d = dym_q * dxm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_ld) begin
      key_q <= req_i.key;
    end
    if (cmd_i.prev_ld) begin
      pk_q <= rk_q;
      pv_q <= rv_q;
    end
    if (cmd_i.diff_ld) begin
      dym_q  <= dy_d[QW] ? dyn[QW-1:0] : dy_d[QW-1:0];
      dxm_q  <= dx_d[QW] ? dxn[QW-1:0] : dx_d[QW-1:0];
      w_q    <= w_d[QW-1:0];
      wpos_q <= !w_d[QW] && (w_d != '0);
      neg_q  <= dy_d[QW] ^ dx_d[QW];
      y1_q   <= pv_q;
    end
    if (cmd_i.mul_ld) begin
      prod_q <= prod_d;
    end
  end

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (w_q),
    .done_o     (div_done),
    .quo_o      (quo)
  );

  // y1 +/- quotient, saturated to Q16.16
  assign y1x = (QW+2)'(y1_q);
  assign qx  = signed'({2'b00, quo[QW-1:0]});
  assign sum = neg_q ? (y1x - qx) : (y1x + qx);

  always_comb begin
    if (|quo[ProdW-1:QW]) begin
      sat_res = neg_q ? QMin : QMax;
    end else if (sum > (QW+2)'(QMax)) begin
      sat_res = QMax;
    end else if (sum < (QW+2)'(QMin)) begin
      sat_res = QMin;
    end else begin
      sat_res = sum[QW-1:0];
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      ResLow:    res_d = y1_q;
      ResInterp: res_d = sat_res;
      default:   res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_we) begin
      rsp_q.result <= res_d;
      rsp_q.status <= cmd_i.rsp_status;
    end
  end

  assign sts_o.full     = (cnt_q == CntW'(TableDepth));
  assign sts_o.few      = (cnt_q < CntW'(2));
  assign sts_o.ge       = (rk_q >= key_q);
  assign sts_o.last     = (ptr_q == cnt_q);
  assign sts_o.wpos     = wpos_q;
  assign sts_o.div_done = div_done;
  assign rsp_o          = rsp_q;

endmodule

[sv/pli_ctrl.sv]
// Controller state machine: request decode, table scan sequencing and
// arithmetic stage control. Depends on pli_pkg.
module pli_ctrl import pli_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    dp_o,
  output logic       busy_o,
  output logic       done_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SPrime  = 3'd1;
  localparam logic [2:0] SLoad0  = 3'd2;
  localparam logic [2:0] SScan   = 3'd3;
  localparam logic [2:0] SDiff   = 3'd4;
  localparam logic [2:0] SMult   = 3'd5;
  localparam logic [2:0] SDstart = 3'd6;
  localparam logic [2:0] SDivw   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    dp_o    = '0;
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          case (cmd_i)
            CmdAppend: begin
              dp_o.rsp_we = 1'b1;
              if (sts_i.full) begin
                dp_o.rsp_status = StFull;
              end else begin
                dp_o.wr         = 1'b1;
                dp_o.rsp_status = StStored;
              end
            end
            CmdClear: begin
              dp_o.clr        = 1'b1;
              dp_o.rsp_we     = 1'b1;
              dp_o.rsp_status = StStored;
            end
            CmdQuery: begin
              if (sts_i.few) begin
                dp_o.rsp_we     = 1'b1;
                dp_o.rsp_status = StNoBracket;
              end else begin
                dp_o.key_ld  = 1'b1;
                dp_o.ptr_clr = 1'b1;
                state_d      = SPrime;
              end
            end
            default: ;
          endcase
        end
      end
      SPrime: begin
        dp_o.rd      = 1'b1;
        dp_o.ptr_inc = 1'b1;
        state_d      = SLoad0;
      end
      SLoad0: begin
        dp_o.prev_ld = 1'b1;
        dp_o.rd      = 1'b1;
        dp_o.ptr_inc = 1'b1;
        state_d      = SScan;
      end
      SScan: begin
        // data register holds entry ptr-1; ptr == count means it was the last
        if (sts_i.ge) begin
          state_d = SDiff;
        end else if (sts_i.last) begin
          dp_o.rsp_we     = 1'b1;
          dp_o.rsp_status = StNoBracket;
          state_d         = SIdle;
        end else begin
          dp_o.prev_ld = 1'b1;
          dp_o.rd      = 1'b1;
          dp_o.ptr_inc = 1'b1;
        end
      end
      SDiff: begin
        dp_o.diff_ld = 1'b1;
        state_d      = SMult;
      end
      SMult: begin
        if (!sts_i.wpos) begin
          dp_o.rsp_we     = 1'b1;
          dp_o.rsp_status = StInterp;
          dp_o.res_sel    = ResLow;
          state_d         = SIdle;
        end else begin
          dp_o.mul_ld = 1'b1;
          state_d     = SDstart;
        end
      end
      SDstart: begin
        dp_o.div_start = 1'b1;
        state_d        = SDivw;
      end
      SDivw: begin
        if (sts_i.div_done) begin
          dp_o.rsp_we     = 1'b1;
          dp_o.rsp_status = StInterp;
          dp_o.res_sel    = ResInterp;
          state_d         = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= dp_o.rsp_we;
    end
  end

  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;

endmodule
